[rtl/nsr_pkg.sv]
// Shared types and constants for the Newton square root block.
// Used by the top level and by the shared divider; no dependencies.
package nsr_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned ERR_W    = 31;
   localparam int unsigned ITER_W   = 6;
   localparam int unsigned DVD_W    = 64;
   localparam int unsigned STEP_W   = 7;
   localparam int unsigned CSR_IDX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_GUESS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE_PERCENT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERATIONS    = 2'd2;

   // Reset values: 5.0 in Q16.16, about 0.0005 percent in Q7.24, and 20.
   localparam logic [DATA_W-1:0] GUESS_RESET = 32'd327680;
   localparam logic [ERR_W-1:0]  TOL_RESET   = 31'd8389;
   localparam logic [ITER_W-1:0] MAX_RESET   = 6'd20;

   // 100 percent in Q7.24 and the saturation limit of the error.
   localparam logic [ERR_W-1:0]  ONE_HUNDRED_PCT = 31'd1677721600;
   localparam logic [ERR_W-1:0]  ERR_MAX         = 31'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] U32_MAX         = 32'hFFFF_FFFF;

   // Step counts of the two divisions of one update.
   localparam logic [STEP_W-1:0] QUOT_STEPS = 7'd48;
   localparam logic [STEP_W-1:0] ERR_STEPS  = 7'd63;

   // Command from the sequencer to the shared divider.
   typedef struct packed {
      logic              go;
      logic [STEP_W-1:0] steps;
   } div_cmd_type;

endpackage

[rtl/nsr_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on nsr_pkg for widths and the command struct.
module nsr_divider
   import nsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_cmd_type       cmd,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DVD_W-1:0]  quotient
);

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0]  dq_ff, dq_in;
   logic [DATA_W-1:0] divisor_ff, divisor_in;
   logic [DATA_W:0]   rem_shift;
   logic [DATA_W:0]   rem_sub;
   logic              fits;

   // The dividend is loaded left-justified; quotient bits enter at the bottom.
   assign rem_shift = {rem_ff, dq_ff[DVD_W-1]};
   assign fits      = rem_shift >= {1'b0, divisor_ff};
   assign rem_sub   = rem_shift - {1'b0, divisor_ff};

   always_comb begin
      active_in  = active_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      divisor_in = divisor_ff;
      if (cmd.go) begin
         active_in  = 1'b1;
         count_in   = cmd.steps;
         rem_in     = '0;
         dq_in      = dividend;
         divisor_in = divisor;
      end else if (active_ff) begin
         rem_in   = fits ? rem_sub[DATA_W-1:0] : rem_shift[DATA_W-1:0];
         dq_in    = {dq_ff[DVD_W-2:0], fits};
         count_in = count_ff - 7'd1;
         if (count_ff == 7'd1) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

[rtl/newton_square_root.sv]
// Newton (divide-and-average) square root of an unsigned Q16.16 radicand.
// Each update walks UPDATE, DIV1, AVG, DIFF, MUL, DIV2 and CHECK in turn; rsp_valid rises
// after the last update's CHECK; a zero estimate skips a divider pass and is shorter.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// The receiver cannot stall: results show for exactly one cycle on rsp_valid.
// Reset is synchronous, active high; it restores the configuration defaults.
module newton_square_root
   import nsr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [DATA_W-1:0]    req_radicand,
   output logic                 rsp_valid,
   output logic [DATA_W-1:0]    rsp_root,
   output logic [ERR_W-1:0]     rsp_relative_error,
   output logic [ITER_W-1:0]    rsp_iterations_used,
   output logic                 rsp_converged,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_write_data
);

   // Sequencer codes. One update walks UPDATE through CHECK once.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;  // save old estimate, launch a / x
   localparam logic [2:0] ST_DIV1   = 3'd2;  // wait for the quotient
   localparam logic [2:0] ST_AVG    = 3'd3;  // average estimate and quotient
   localparam logic [2:0] ST_DIFF   = 3'd4;  // absolute change of the estimate
   localparam logic [2:0] ST_MUL    = 3'd5;  // scale by 100 and launch the error division
   localparam logic [2:0] ST_DIV2   = 3'd6;  // wait for the error
   localparam logic [2:0] ST_CHECK  = 3'd7;  // stop test

   // Configuration registers.
   logic [DATA_W-1:0] guess_ff, guess_in;
   logic [ERR_W-1:0]  tol_ff, tol_in;
   logic [ITER_W-1:0] max_ff, max_in;

   // Working state of one transaction.
   logic [2:0]        state_ff, state_in;
   logic [DATA_W-1:0] radicand_ff, radicand_in;
   logic [DATA_W-1:0] est_ff, est_in;
   logic [DATA_W-1:0] prev_ff, prev_in;
   logic [47:0]       quot_ff, quot_in;
   logic [DATA_W-1:0] diff_ff, diff_in;
   logic [ITER_W-1:0] count_ff, count_in;
   logic [ERR_W-1:0]  err_ff, err_in;
   logic              valid_ff, valid_in;
   logic              conv_ff, conv_in;

   // Shared divider hookup.
   div_cmd_type       div_cmd;
   logic [DVD_W-1:0]  div_dividend;
   logic [DATA_W-1:0] div_divisor;
   logic              div_done;
   logic [DVD_W-1:0]  div_quotient;

   logic [48:0]       avg_sum;
   logic [38:0]       scaled_diff;

   nsr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // x + q is at most 49 bits wide; halving it may still overflow 32 bits.
   assign avg_sum = {17'd0, prev_ff} + {1'b0, quot_ff};

   // 100 * d as shifts and adds: 64 + 32 + 4.
   assign scaled_diff = {1'b0, diff_ff, 6'd0} + {2'd0, diff_ff, 5'd0}
                      + {5'd0, diff_ff, 2'd0};

   // Configuration writes; an index beyond the list is ignored.
   always_comb begin
      guess_in = guess_ff;
      tol_in   = tol_ff;
      max_in   = max_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INITIAL_GUESS:     guess_in = csr_write_data;
            CSR_TOLERANCE_PERCENT: tol_in   = csr_write_data[ERR_W-1:0];
            CSR_MAX_ITERATIONS:    max_in   = csr_write_data[ITER_W-1:0];
            default:               ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      radicand_in  = radicand_ff;
      est_in       = est_ff;
      prev_in      = prev_ff;
      quot_in      = quot_ff;
      diff_in      = diff_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      conv_in      = conv_ff;
      valid_in     = 1'b0;
      div_cmd      = '{go: 1'b0, steps: QUOT_STEPS};
      div_dividend = {radicand_ff, 32'd0};
      div_divisor  = est_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // A new transaction starts from the configured guess, the count
               // at one and the error at 100 percent.
               radicand_in = req_radicand;
               est_in      = guess_ff;
               count_in    = 6'd1;
               err_in      = ONE_HUNDRED_PCT;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            prev_in = est_ff;
            if (est_ff == '0) begin
               // Division by a zero estimate saturates the quotient.
               quot_in  = {16'd0, U32_MAX};
               state_in = ST_AVG;
            end else begin
               // (a << 16) / x: the dividend sits left-justified, 48 steps.
               div_cmd.go = 1'b1;
               state_in   = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               quot_in  = div_quotient[47:0];
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            est_in   = (avg_sum[48:33] != '0) ? U32_MAX : avg_sum[32:1];
            count_in = count_ff + 6'd1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = (est_ff >= prev_ff) ? est_ff - prev_ff : prev_ff - est_ff;
            // A zero new estimate leaves the error as it was.
            state_in = (est_ff == '0) ? ST_CHECK : ST_MUL;
         end
         ST_MUL: begin
            // (100 * d) << 24 is 63 bits; it goes in left-justified.
            div_cmd      = '{go: 1'b1, steps: ERR_STEPS};
            div_dividend = {scaled_diff, 25'd0};
            state_in     = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_done) begin
               err_in   = (div_quotient[62:31] != '0) ? ERR_MAX : div_quotient[30:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((err_ff > tol_ff) && (count_ff < max_ff)) begin
               state_in = ST_UPDATE;
            end else begin
               // Converged is judged on the error alone, even at the limit.
               conv_in  = (err_ff <= tol_ff);
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         guess_ff <= GUESS_RESET;
         tol_ff   <= TOL_RESET;
         max_ff   <= MAX_RESET;
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         guess_ff <= guess_in;
         tol_ff   <= tol_in;
         max_ff   <= max_in;
         state_ff <= state_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      radicand_ff <= radicand_in;
      est_ff      <= est_in;
      prev_ff     <= prev_in;
      quot_ff     <= quot_in;
      diff_ff     <= diff_in;
      err_ff      <= err_in;
      conv_ff     <= conv_in;
   end

   // The working registers hold still through the strobe cycle, so the result
   // reads straight from them.
   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = valid_ff;
   assign rsp_root            = est_ff;
   assign rsp_relative_error  = err_ff;
   assign rsp_iterations_used = count_ff;
   assign rsp_converged       = conv_ff;

endmodule
